// ===== hw/rtl/ihrp_pkg.sv =====
// Shared types, constants and the hex digit decoder of the HEX record parser.
package ihrp_pkg;

  // Image buffer size in bytes; writes must end at or below it
  localparam int unsigned IMAGE_BYTES = 131072;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int RELOC_W  = 18;
  localparam int WADDR_W  = 17;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 18;
  localparam int BASE_W   = 32;
  localparam int START_W  = BASE_W + 1;
  localparam int CHECK_W  = START_W + 1;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_CHAR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Finish status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FORMAT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // Record types
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_LINEAR  = 8'h04;

  // Characters
  localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  // One result beat
  typedef struct packed {
    logic                kind;
    logic [WADDR_W-1:0]  write_address;
    logic [BYTE_W-1:0]   write_byte;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   image_size;
  } result_t;

  // Decoded hex digit: ok flag and nibble
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // ASCII hex digit decode, either letter case
  function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ihrp_core.sv =====
// Record parser: character decode, record state machine and result generation.
module ihrp_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [ihrp_pkg::CMD_W-1:0]          command,
  input  logic [ihrp_pkg::CHAR_W-1:0]         char_code,
  input  logic [ihrp_pkg::RELOC_W-1:0]        reloc,
  output logic                                res_valid,
  output ihrp_pkg::result_t                   res
);

  typedef enum logic [3:0] {
    PH_SEEK, PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_EXT, PH_CHECK, PH_EOL, PH_DONE
  } phase_t;

  phase_t                            phase, phase_next;
  logic                              nib_full, nib_full_next;
  logic [3:0]                        nib, nib_next;
  logic                              byte_sel, byte_sel_next;
  logic [7:0]                        record_length, record_length_next;
  logic [15:0]                       field_value, field_value_next;
  logic [7:0]                        record_type, record_type_next;
  logic [7:0]                        bytes_done, bytes_done_next;
  logic [7:0]                        running_sum, running_sum_next;
  logic [ihrp_pkg::BASE_W-1:0]       base_address, base_address_next;
  logic [ihrp_pkg::SIZE_W-1:0]       record_start, record_start_next;
  logic                              good_line_seen, good_line_seen_next;
  logic [ihrp_pkg::SIZE_W-1:0]       last_image_end, last_image_end_next;

  ihrp_pkg::hex_digit_t              dig;
  logic [7:0]                        b;
  logic [7:0]                        sum_b;
  logic [ihrp_pkg::START_W-1:0]      start_full;
  logic [ihrp_pkg::CHECK_W-1:0]      end_check;
  logic                              overflow;
  logic [ihrp_pkg::WADDR_W-1:0]      wr_addr;
  logic                              fin_req;
  logic [ihrp_pkg::STATUS_W-1:0]     fin_status;
  logic [ihrp_pkg::STATUS_W-1:0]     fin_status_eff;
  logic                              wr_req;

  // Datapath helpers
  assign dig        = ihrp_pkg::hex_decode(char_code);
  assign b          = {nib, dig.value};
  assign sum_b      = running_sum + b;
  assign start_full = {1'b0, base_address} + ihrp_pkg::START_W'(field_value);
  assign end_check  = ihrp_pkg::CHECK_W'(reloc) + {1'b0, start_full}
                      + ihrp_pkg::CHECK_W'(record_length);
  assign overflow   = end_check > ihrp_pkg::CHECK_W'(ihrp_pkg::IMAGE_BYTES);
  assign wr_addr    = reloc[ihrp_pkg::WADDR_W-1:0] + record_start[ihrp_pkg::WADDR_W-1:0]
                      + ihrp_pkg::WADDR_W'(bytes_done);

  // Next state and result request
  always_comb begin
    phase_next          = phase;
    nib_full_next       = nib_full;
    nib_next            = nib;
    byte_sel_next       = byte_sel;
    record_length_next  = record_length;
    field_value_next    = field_value;
    record_type_next    = record_type;
    bytes_done_next     = bytes_done;
    running_sum_next    = running_sum;
    base_address_next   = base_address;
    record_start_next   = record_start;
    good_line_seen_next = good_line_seen;
    last_image_end_next = last_image_end;
    fin_req             = 1'b0;
    fin_status          = ihrp_pkg::ST_OK;
    wr_req              = 1'b0;

    if (command == ihrp_pkg::CMD_RESTART) begin
      phase_next          = PH_SEEK;
      nib_full_next       = 1'b0;
      nib_next            = 4'd0;
      byte_sel_next       = 1'b0;
      record_length_next  = 8'd0;
      field_value_next    = 16'd0;
      record_type_next    = 8'd0;
      bytes_done_next     = 8'd0;
      running_sum_next    = 8'd0;
      base_address_next   = '0;
      record_start_next   = '0;
      good_line_seen_next = 1'b0;
      last_image_end_next = '0;
    end else if (command == ihrp_pkg::CMD_END && phase != PH_DONE) begin
      fin_req = 1'b1;
      if ((phase == PH_SEEK || phase == PH_EOL) && good_line_seen) begin
        fin_status = ihrp_pkg::ST_OK;
      end else begin
        fin_status = ihrp_pkg::ST_FORMAT;
      end
    end else if (command == ihrp_pkg::CMD_CHAR && phase != PH_DONE) begin
      if (phase == PH_SEEK) begin
        if (char_code == ihrp_pkg::CHAR_COLON) begin
          phase_next    = PH_COUNT;
          nib_full_next = 1'b0;
        end
      end else if (phase == PH_EOL) begin
        if (char_code == ihrp_pkg::CHAR_NEWLINE) begin
          phase_next = PH_SEEK;
        end
      end else if (!dig.ok) begin
        fin_req    = 1'b1;
        fin_status = ihrp_pkg::ST_FORMAT;
      end else if (!nib_full) begin
        nib_full_next = 1'b1;
        nib_next      = dig.value;
      end else begin
        nib_full_next = 1'b0;
        // Full byte assembled: advance the record
        unique case (phase) inside
          PH_COUNT: begin
            record_length_next = b;
            running_sum_next   = b;
            byte_sel_next      = 1'b0;
            field_value_next   = 16'd0;
            phase_next         = PH_ADDR;
          end
          PH_ADDR, PH_EXT: begin
            field_value_next = {field_value[7:0], b};
            running_sum_next = sum_b;
            byte_sel_next    = ~byte_sel;
            if (byte_sel) begin
              byte_sel_next = 1'b0;
              if (phase == PH_ADDR) begin
                phase_next = PH_TYPE;
              end else begin
                if (record_type == ihrp_pkg::REC_SEGMENT) begin
                  base_address_next = {12'd0, field_value[7:0], b, 4'd0};
                end else begin
                  base_address_next = {field_value[7:0], b, 16'd0};
                end
                phase_next = PH_CHECK;
              end
            end
          end
          PH_TYPE: begin
            record_type_next = b;
            running_sum_next = sum_b;
            bytes_done_next  = 8'd0;
            if (b == ihrp_pkg::REC_DATA) begin
              record_start_next = start_full[ihrp_pkg::SIZE_W-1:0];
              if (overflow) begin
                fin_req    = 1'b1;
                fin_status = ihrp_pkg::ST_OVERFLOW;
              end else begin
                last_image_end_next = start_full[ihrp_pkg::SIZE_W-1:0]
                                      + ihrp_pkg::SIZE_W'(record_length);
                phase_next = (record_length != 8'd0) ? PH_DATA : PH_CHECK;
              end
            end else if (b == ihrp_pkg::REC_SEGMENT || b == ihrp_pkg::REC_LINEAR) begin
              if (record_length != 8'd2) begin
                fin_req    = 1'b1;
                fin_status = ihrp_pkg::ST_FORMAT;
              end else begin
                byte_sel_next    = 1'b0;
                field_value_next = 16'd0;
                phase_next       = PH_EXT;
              end
            end else begin
              phase_next = (record_length != 8'd0) ? PH_DATA : PH_CHECK;
            end
          end
          PH_DATA: begin
            running_sum_next = sum_b;
            wr_req           = (record_type == ihrp_pkg::REC_DATA);
            bytes_done_next  = bytes_done + 8'd1;
            if (bytes_done + 8'd1 == record_length) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (sum_b != 8'd0) begin
              fin_req    = 1'b1;
              fin_status = ihrp_pkg::ST_FORMAT;
            end else begin
              good_line_seen_next = 1'b1;
              if (record_type == ihrp_pkg::REC_EOF) begin
                fin_req    = 1'b1;
                fin_status = ihrp_pkg::ST_OK;
              end else begin
                phase_next = PH_EOL;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (fin_req) begin
      phase_next = PH_DONE;
    end
  end

  // Errors before any good line report as format errors
  assign fin_status_eff = (fin_status != ihrp_pkg::ST_OK && !good_line_seen_next)
                          ? ihrp_pkg::ST_FORMAT : fin_status;

  // Result beat
  always_comb begin
    res_valid = accept && (fin_req || wr_req);
    res       = '0;
    if (fin_req) begin
      res.kind   = ihrp_pkg::KIND_FINISH;
      res.status = fin_status_eff;
      if (fin_status_eff == ihrp_pkg::ST_OK) begin
        res.image_size = (last_image_end != '0) ? last_image_end : ihrp_pkg::SIZE_W'(1);
      end
    end else begin
      res.kind          = ihrp_pkg::KIND_WRITE;
      res.write_address = wr_addr;
      res.write_byte    = b;
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SEEK;
      nib_full       <= 1'b0;
      nib            <= 4'd0;
      byte_sel       <= 1'b0;
      record_length  <= 8'd0;
      field_value    <= 16'd0;
      record_type    <= 8'd0;
      bytes_done     <= 8'd0;
      running_sum    <= 8'd0;
      base_address   <= '0;
      record_start   <= '0;
      good_line_seen <= 1'b0;
      last_image_end <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      nib_full       <= nib_full_next;
      nib            <= nib_next;
      byte_sel       <= byte_sel_next;
      record_length  <= record_length_next;
      field_value    <= field_value_next;
      record_type    <= record_type_next;
      bytes_done     <= bytes_done_next;
      running_sum    <= running_sum_next;
      base_address   <= base_address_next;
      record_start   <= record_start_next;
      good_line_seen <= good_line_seen_next;
      last_image_end <= last_image_end_next;
    end
  end

  // Once finished, only a restart leaves the done phase
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE && !(accept && command == ihrp_pkg::CMD_RESTART)) |=> phase == PH_DONE)
    else $error("parser left done phase without restart");

  // Image writes come only from data bytes of data records
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == ihrp_pkg::KIND_WRITE) |->
      (phase == PH_DATA && record_type == ihrp_pkg::REC_DATA))
    else $error("write beat outside a data record");

  // A finish beat always moves the parser to done
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == ihrp_pkg::KIND_FINISH) |=> phase == PH_DONE)
    else $error("finish beat without entering done");

endmodule

// ===== hw/rtl/ihrp_obuf.sv =====
// Two-entry result buffer between the parser and the output channel.
module ihrp_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ihrp_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output ihrp_pkg::result_t head
);

  logic [1:0]        count, count_next;
  ihrp_pkg::result_t slot1;
  logic              pop;

  assign pop        = (count != 2'd0) && !out_stall;
  assign full       = (count == 2'd2);
  assign out_valid  = (count != 2'd0);
  assign count_next = count + 2'(push) - 2'(pop);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (count == 2'd0 || (pop && count == 2'd1)) begin
      if (push) begin
        head <= push_data;
      end
    end else if (pop && count == 2'd2) begin
      head <= slot1;
    end
    if (push && count == 2'd1 && !pop) begin
      slot1 <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full result buffer");

  // A full buffer that is not drained stays full
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && out_stall) |=> count == 2'd2)
    else $error("result buffer lost an entry while stalled");

endmodule

// ===== hw/rtl/intel_hex_record_parser.sv =====
// Top level of the Intel HEX record parser: ports, relocation register, wiring.
// Takes one file character per cycle (command 0), end of input (1) or restart (2),
// and accepts a new beat every clock as long as the two-entry result buffer is not
// full; each beat is decoded and applied to the record state as it is accepted, and
// its result, if any, is queued in the result buffer behind earlier results. A data byte
// yields one write beat at load_offset + base + record address + index; an end
// record, end of input or the first error yields one finish beat with status and
// image size, after which input is ignored until restart. Write load_offset
// only while no beat is in flight; cfg_ready is always high.
module intel_hex_record_parser (
  input  logic                              clk,
  input  logic                              rst,
  // Input character channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ihrp_pkg::CMD_W-1:0]        command,
  input  logic [ihrp_pkg::CHAR_W-1:0]       char_code,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              kind,
  output logic [ihrp_pkg::WADDR_W-1:0]      write_address,
  output logic [ihrp_pkg::BYTE_W-1:0]       write_byte,
  output logic [ihrp_pkg::STATUS_W-1:0]     status,
  output logic [ihrp_pkg::SIZE_W-1:0]       image_size,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ihrp_pkg::RELOC_W-1:0]      load_offset
);

  logic [ihrp_pkg::RELOC_W-1:0] reloc;
  logic                         accept;
  logic                         res_valid;
  ihrp_pkg::result_t            res;
  ihrp_pkg::result_t            head;
  logic                         full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  // Relocation register
  always_ff @(posedge clk) begin
    if (rst) begin
      reloc <= '0;
    end else if (cfg_valid && cfg_ready) begin
      reloc <= load_offset;
    end
  end

  ihrp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .char_code (char_code),
    .reloc     (reloc),
    .res_valid (res_valid),
    .res       (res)
  );

  ihrp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Result beat fields
  assign kind          = head.kind;
  assign write_address = head.write_address;
  assign write_byte    = head.write_byte;
  assign status        = head.status;
  assign image_size    = head.image_size;

endmodule
